// File: src/lsb_pixel_embed_extract_defines.svh
// Assertion macros for the pixel embed/extract block.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message.
`ifndef LSB_PIXEL_EMBED_EXTRACT_DEFINES_SVH
`define LSB_PIXEL_EMBED_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/lpe_pkg.sv
package lpe_pkg;

    // Fixed field and register widths
    localparam int CHAN_W     = 8;
    localparam int NIB_W      = 4;
    localparam int IDX_W      = 25;
    localparam int PL_W       = 23;
    localparam int IMG_W      = 25;
    localparam int LEN_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE           = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAYLOAD_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_PIXELS   = 2'd2;

    // Mode codes
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Image pixel count after reset
    localparam logic [IMG_W-1:0] IMG_RESET = 25'd1;

    // One incoming pixel word
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] payload_byte;
    } t_pixel;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic             mode;
        logic [PL_W-1:0]  payload_length;
        logic [IMG_W-1:0] eff_pixels;
        logic             fail;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] out_byte;
        logic              byte_valid;
        logic              byte_last;
        logic              length_ready;
        logic [LEN_W-1:0]  decoded_length;
        logic              status;
    } t_result;

endpackage

// File: src/lsb_pixel_embed_extract.sv
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+-----------------------------------------
// pixel in | input     | i_valid / o_stall  | RGBA channels and payload byte
// pixel out| output    | o_valid / i_stall  | RGBA, recovered byte, length and status
// config   | input     | i_cfg_wr_en        | register index and write data
//
// One pixel per clock while the output is not stalled; an accepted pixel goes
// through the input register, then the result register, to reach the output.
// All per-pixel work sits between those two registers; the pixel counter and
// header/payload state advance as a word moves into the result register.
// Synchronous active-low reset clears the pipeline valids, the stream state
// and the configuration registers (embed mode, zero length, one pixel).
// A stall on the output holds the result register; the input register keeps
// taking a word until it is full too, then o_stall rises.
`include "lsb_pixel_embed_extract_defines.svh"

module lsb_pixel_embed_extract #(
    parameter int HEADER_BYTES    = 4,
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    input  logic [7:0]                     i_alpha_in,
    input  logic [7:0]                     i_payload_byte,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic [7:0]                     o_alpha_out,
    output logic [7:0]                     o_out_byte,
    output logic                           o_byte_valid,
    output logic                           o_byte_last,
    output logic                           o_length_ready,
    output logic [31:0]                    o_decoded_length,
    output logic                           o_status,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [lpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);
    import lpe_pkg::*;

    t_cfg    cfg;
    t_pixel  r_in;
    t_pixel  n_in;
    logic    r_in_valid;
    logic    n_in_valid;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    advance;
    logic    fire;
    logic    take;

    lpe_cfg_regs #(
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    lpe_engine #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_pix   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Pipeline handshake: result register frees when empty or taken
    always_comb begin
        advance = !r_out_valid || !i_stall;
        fire    = r_in_valid && advance;
        o_stall = r_in_valid && !advance;
        take    = i_valid && !o_stall;

        n_in.red          = i_red_in;
        n_in.green        = i_green_in;
        n_in.blue         = i_blue_in;
        n_in.alpha        = i_alpha_in;
        n_in.payload_byte = i_payload_byte;

        n_in_valid  = take || (r_in_valid && !advance);
        n_out_valid = fire || (r_out_valid && i_stall);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture input word and result word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= n_in;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red_out        = r_res.red;
    assign o_green_out      = r_res.green;
    assign o_blue_out       = r_res.blue;
    assign o_alpha_out      = r_res.alpha;
    assign o_out_byte       = r_res.out_byte;
    assign o_byte_valid     = r_res.byte_valid;
    assign o_byte_last      = r_res.byte_last;
    assign o_length_ready   = r_res.length_ready;
    assign o_decoded_length = r_res.decoded_length;
    assign o_status         = r_res.status;

    `LPE_ASSERT_IMP(a_last_has_byte, i_clk, i_rst_n, o_valid && o_byte_last, o_byte_valid, "byte_last without byte_valid")
    `LPE_ASSERT_IMP(a_status_no_extract, i_clk, i_rst_n, o_valid && o_status, !o_byte_valid && !o_length_ready, "status raised on an extract result")
    `LPE_ASSERT_IMP(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled while result register is empty")
    `LPE_ASSERT_NXT(a_take_fills_input, i_clk, i_rst_n, i_valid && !o_stall, r_in_valid, "accepted word not held in input register")

endmodule

// File: src/lpe_cfg_regs.sv
module lpe_cfg_regs #(
    parameter int HEADER_BYTES    = 4,
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    output lpe_pkg::t_cfg                  o_cfg
);
    import lpe_pkg::*;

    localparam logic [31:0]      CAP32   = 32'd1 << MAX_PIXELS_LOG2;
    localparam logic [IMG_W-1:0] CAP     = CAP32[IMG_W-1:0];
    localparam logic [IMG_W-1:0] HDR_LEN = IMG_W'(HEADER_BYTES);

    logic             r_mode;
    logic [PL_W-1:0]  r_payload_length;
    logic [IMG_W-1:0] r_image_pixels;
    logic             n_mode;
    logic [PL_W-1:0]  n_payload_length;
    logic [IMG_W-1:0] n_image_pixels;
    logic [IMG_W-1:0] eff;
    logic [IMG_W-1:0] need;

    // Decode register writes; unknown indexes are dropped
    always_comb begin
        n_mode           = r_mode;
        n_payload_length = r_payload_length;
        n_image_pixels   = r_image_pixels;
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MODE:           n_mode           = i_cfg_wr_data[0];
                CFG_PAYLOAD_LENGTH: n_payload_length = i_cfg_wr_data[PL_W-1:0];
                CFG_IMAGE_PIXELS:   n_image_pixels   = i_cfg_wr_data[IMG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_EMBED;
            r_payload_length <= '0;
            r_image_pixels   <= IMG_RESET;
        end else begin
            r_mode           <= n_mode;
            r_payload_length <= n_payload_length;
            r_image_pixels   <= n_image_pixels;
        end
    end

    // Clamp the pixel count and check that header plus payload fits
    always_comb begin
        if ({7'd0, r_image_pixels} < CAP32) begin
            eff = r_image_pixels;
        end else begin
            eff = CAP;
        end
        need = {2'd0, r_payload_length} + HDR_LEN;
        o_cfg.mode           = r_mode;
        o_cfg.payload_length = r_payload_length;
        o_cfg.eff_pixels     = eff;
        o_cfg.fail           = (need >= (eff >> 1));
    end

endmodule

// File: src/lpe_engine.sv
module lpe_engine #(
    parameter int HEADER_BYTES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lpe_pkg::t_pixel  i_pix,
    input  lpe_pkg::t_cfg    i_cfg,
    output lpe_pkg::t_result o_res
);
    import lpe_pkg::*;

    localparam logic [IDX_W-1:0] HDR_PX   = IDX_W'(2 * HEADER_BYTES);
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(2 * HEADER_BYTES - 1);

    logic [IDX_W-1:0]  r_pixel_index;
    logic [NIB_W-1:0]  r_low_nibble_hold;
    logic [CHAN_W-1:0] r_held_payload_byte;
    logic [LEN_W-1:0]  r_length_acc;
    logic [LEN_W-1:0]  r_bytes_emitted;
    logic [IDX_W-1:0]  n_pixel_index;
    logic [NIB_W-1:0]  n_low_nibble_hold;
    logic [CHAN_W-1:0] n_held_payload_byte;
    logic [LEN_W-1:0]  n_length_acc;
    logic [LEN_W-1:0]  n_bytes_emitted;

    logic              in_img;
    logic              in_hdr;
    logic [IDX_W-1:0]  rel;
    logic              in_pay;
    logic [4:0]        nib_sh;
    logic [LEN_W-1:0]  pl_wide;
    logic [NIB_W-1:0]  tx_nib;
    logic              tx_write;
    logic [NIB_W-1:0]  rx_nib;
    logic [LEN_W-1:0]  be_inc;

    // Position of this pixel within the header or payload stream
    always_comb begin
        in_img  = r_pixel_index < i_cfg.eff_pixels;
        in_hdr  = r_pixel_index < HDR_PX;
        rel     = r_pixel_index - HDR_PX;
        in_pay  = {1'b0, rel} < {2'b00, i_cfg.payload_length, 1'b0};
        nib_sh  = {r_pixel_index[2:0], 2'b00};
        pl_wide = {{(LEN_W-PL_W){1'b0}}, i_cfg.payload_length};
        rx_nib  = {i_pix.alpha[0], i_pix.blue[0], i_pix.green[0], i_pix.red[0]};
        be_inc  = r_bytes_emitted + 32'd1;
    end

    // Per-pixel embed or extract work and state update
    always_comb begin
        n_pixel_index       = r_pixel_index;
        n_low_nibble_hold   = r_low_nibble_hold;
        n_held_payload_byte = r_held_payload_byte;
        n_length_acc        = r_length_acc;
        n_bytes_emitted     = r_bytes_emitted;
        tx_nib              = '0;
        tx_write            = 1'b0;

        o_res.red            = i_pix.red;
        o_res.green          = i_pix.green;
        o_res.blue           = i_pix.blue;
        o_res.alpha          = i_pix.alpha;
        o_res.out_byte       = '0;
        o_res.byte_valid     = 1'b0;
        o_res.byte_last      = 1'b0;
        o_res.length_ready   = 1'b0;
        o_res.decoded_length = '0;
        o_res.status         = 1'b0;

        if (i_cfg.mode == MODE_EMBED) begin
            o_res.status = i_cfg.fail;
            if (!i_cfg.fail && in_img) begin
                if (in_hdr) begin
                    tx_nib   = pl_wide[nib_sh +: NIB_W];
                    tx_write = 1'b1;
                end else if (in_pay) begin
                    if (!rel[0]) begin
                        n_held_payload_byte = i_pix.payload_byte;
                        tx_nib              = i_pix.payload_byte[NIB_W-1:0];
                    end else begin
                        tx_nib = r_held_payload_byte[CHAN_W-1:NIB_W];
                    end
                    tx_write = 1'b1;
                end
            end
            if (tx_write) begin
                o_res.red   = {i_pix.red[CHAN_W-1:1], tx_nib[0]};
                o_res.green = {i_pix.green[CHAN_W-1:1], tx_nib[1]};
                o_res.blue  = {i_pix.blue[CHAN_W-1:1], tx_nib[2]};
                o_res.alpha = {i_pix.alpha[CHAN_W-1:1], tx_nib[3]};
            end
        end else begin
            if (in_img) begin
                if (in_hdr) begin
                    n_length_acc       = r_length_acc | ({28'd0, rx_nib} << nib_sh);
                    o_res.length_ready = (r_pixel_index == HDR_LAST);
                end else if (r_bytes_emitted < r_length_acc) begin
                    if (!rel[0]) begin
                        n_low_nibble_hold = rx_nib;
                    end else begin
                        o_res.out_byte   = {rx_nib, r_low_nibble_hold};
                        o_res.byte_valid = 1'b1;
                        n_bytes_emitted  = be_inc;
                        o_res.byte_last  = (be_inc == r_length_acc);
                    end
                end
            end
            if (r_pixel_index >= HDR_LAST) begin
                o_res.decoded_length = n_length_acc;
            end
        end

        // Saturate the pixel position
        if (r_pixel_index != '1) begin
            n_pixel_index = r_pixel_index + 25'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_index       <= '0;
            r_low_nibble_hold   <= '0;
            r_held_payload_byte <= '0;
            r_length_acc        <= '0;
            r_bytes_emitted     <= '0;
        end else if (i_fire) begin
            r_pixel_index       <= n_pixel_index;
            r_low_nibble_hold   <= n_low_nibble_hold;
            r_held_payload_byte <= n_held_payload_byte;
            r_length_acc        <= n_length_acc;
            r_bytes_emitted     <= n_bytes_emitted;
        end
    end

endmodule

// File: test/lsb_pixel_embed_extract_tb.sv
`timescale 1ns / 1ps

module lsb_pixel_embed_extract_tb;
    import lpe_pkg::*;

    localparam int HEADER_BYTES    = 4;
    localparam int MAX_PIXELS_LOG2 = 24;
    localparam int HDR_PIX         = 2 * HEADER_BYTES;

    localparam logic [IMG_W-1:0] PIX_CAP    = IMG_W'(1 << MAX_PIXELS_LOG2);
    localparam logic [IMG_W-1:0] IMG_MAX    = '1;
    localparam logic [IDX_W-1:0] POS_MAX    = '1;
    localparam logic [PL_W-1:0]  PL_MAX     = '1;
    // Largest length that still fits a full-size image, and the first that does not
    localparam logic [PL_W-1:0]  PL_FIT_MAX = PL_MAX - 23'd4;
    localparam logic [PL_W-1:0]  PL_OVER    = PL_MAX - 23'd3;

    localparam int DIR_N        = 17;
    localparam int TOTAL_ITEMS  = 1950;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRESSURE_AT  = 700;
    localparam int QUIET_LIMIT  = 3000;

    typedef struct {
        logic             mode;
        logic [PL_W-1:0]  plen;
        logic [IMG_W-1:0] img;
        t_pixel           px;
        bit               typed;
        t_result          want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_red_in       = '0;
    logic [7:0]            i_green_in     = '0;
    logic [7:0]            i_blue_in      = '0;
    logic [7:0]            i_alpha_in     = '0;
    logic [7:0]            i_payload_byte = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [7:0]            o_red_out;
    logic [7:0]            o_green_out;
    logic [7:0]            o_blue_out;
    logic [7:0]            o_alpha_out;
    logic [7:0]            o_out_byte;
    logic                  o_byte_valid;
    logic                  o_byte_last;
    logic                  o_length_ready;
    logic [31:0]           o_decoded_length;
    logic                  o_status;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data  = '0;

    // Register copies as last written
    logic             cfg_mode = MODE_EMBED;
    logic [PL_W-1:0]  cfg_plen = '0;
    logic [IMG_W-1:0] cfg_img  = IMG_RESET;

    // Stream state of the image
    logic [IDX_W-1:0] pix_pos   = '0;
    logic [NIB_W-1:0] nib_low   = '0;
    logic [7:0]       held_byte = '0;
    logic [LEN_W-1:0] len_acc   = '0;
    logic [LEN_W-1:0] bytes_out = '0;

    t_result results_due[$];
    int      items_sent   = 0;
    int      err_count    = 0;
    int      burst_left   = 0;
    int      quiet_cycles = 0;
    bit      hold_req     = 1'b0;

    lsb_pixel_embed_extract #(
        .HEADER_BYTES   (HEADER_BYTES),
        .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)
    ) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Embed or recover one pixel word and advance the stream state
    function automatic t_result lsb_pixel_result(input t_pixel px);
        t_result          res;
        logic [IMG_W-1:0] eff;
        logic [31:0]      rel;
        logic [31:0]      wide_len;
        logic [NIB_W-1:0] nib;
        logic             in_image;
        logic             fail;
        logic             wr;
        res       = '0;
        res.red   = px.red;
        res.green = px.green;
        res.blue  = px.blue;
        res.alpha = px.alpha;
        eff       = (cfg_img < PIX_CAP) ? cfg_img : PIX_CAP;
        in_image  = (pix_pos < eff);
        rel       = 32'(pix_pos) - HDR_PIX;
        if (cfg_mode == MODE_EMBED) begin
            fail       = (32'(cfg_plen) + HEADER_BYTES) >= 32'(eff >> 1);
            res.status = fail;
            wr         = 1'b0;
            nib        = '0;
            if (!fail && in_image) begin
                if (pix_pos < HDR_PIX) begin
                    wide_len = 32'(cfg_plen);
                    nib      = NIB_W'(wide_len >> (4 * pix_pos));
                    wr       = 1'b1;
                end else if (rel < 2 * 32'(cfg_plen)) begin
                    // Sample the payload byte on the first pixel of each pair
                    if (!rel[0]) begin
                        held_byte = px.payload_byte;
                        nib       = px.payload_byte[3:0];
                    end else begin
                        nib = held_byte[7:4];
                    end
                    wr = 1'b1;
                end
            end
            if (wr) begin
                res.red[0]   = nib[0];
                res.green[0] = nib[1];
                res.blue[0]  = nib[2];
                res.alpha[0] = nib[3];
            end
        end else begin
            nib = {px.alpha[0], px.blue[0], px.green[0], px.red[0]};
            if (in_image) begin
                if (pix_pos < HDR_PIX) begin
                    len_acc          = len_acc | (32'(nib) << (4 * pix_pos));
                    res.length_ready = (pix_pos == HDR_PIX - 1);
                end else if (bytes_out < len_acc) begin
                    if (!rel[0]) begin
                        nib_low = nib;
                    end else begin
                        res.out_byte   = {nib, nib_low};
                        res.byte_valid = 1'b1;
                        bytes_out      = bytes_out + 32'd1;
                        res.byte_last  = (bytes_out == len_acc);
                    end
                end
            end
            if (pix_pos >= HDR_PIX - 1) res.decoded_length = len_acc;
        end
        if (pix_pos != POS_MAX) pix_pos = pix_pos + 25'd1;
        return res;
    endfunction

    function automatic t_dir_row dir_row(
        input logic             m,
        input logic [PL_W-1:0]  pl,
        input logic [IMG_W-1:0] img,
        input logic [31:0]      rgba,
        input logic [7:0]       pb,
        input bit               typed,
        input logic [31:0]      want_rgba,
        input logic             lr,
        input logic [31:0]      dl,
        input logic             st
    );
        t_dir_row row;
        row.mode  = m;
        row.plen  = pl;
        row.img   = img;
        row.px    = t_pixel'({rgba, pb});
        row.typed = typed;
        row.want  = t_result'({want_rgba, 8'd0, 1'b0, 1'b0, lr, dl, st});
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Offer one word, keeping bursts and gaps on the input side
    task automatic send_pixel(input t_pixel px, input bit typed, input t_result want);
        t_result pred;
        int      gap;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        {i_red_in, i_green_in, i_blue_in, i_alpha_in, i_payload_byte} <= px;
        do @(posedge i_clk); while (o_stall);
        pred = lsb_pixel_result(px);
        results_due.push_back(typed ? want : pred);
        items_sent++;
        burst_left--;
    endtask

    // Drop valid and wait until every pending word has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic m, input logic [PL_W-1:0] pl,
                                input logic [IMG_W-1:0] img);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= CFG_MODE;
        i_cfg_wr_data <= CFG_DATA_W'(m);
        @(posedge i_clk);
        i_cfg_addr    <= CFG_PAYLOAD_LENGTH;
        i_cfg_wr_data <= CFG_DATA_W'(pl);
        @(posedge i_clk);
        i_cfg_addr    <= CFG_IMAGE_PIXELS;
        i_cfg_wr_data <= img;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_mode = m;
        cfg_plen = pl;
        cfg_img  = img;
    endtask

    // Compare each accepted result word with the oldest pending one
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("result word with nothing pending");
                err_count++;
            end else begin
                want = results_due.pop_front();
                check_field("red_out", 32'(want.red), 32'(o_red_out));
                check_field("green_out", 32'(want.green), 32'(o_green_out));
                check_field("blue_out", 32'(want.blue), 32'(o_blue_out));
                check_field("alpha_out", 32'(want.alpha), 32'(o_alpha_out));
                check_field("out_byte", 32'(want.out_byte), 32'(o_out_byte));
                check_field("byte_valid", 32'(want.byte_valid), 32'(o_byte_valid));
                check_field("byte_last", 32'(want.byte_last), 32'(o_byte_last));
                check_field("length_ready", 32'(want.length_ready),
                            32'(o_length_ready));
                check_field("decoded_length", want.decoded_length, o_decoded_length);
                check_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    // End the run when no word moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("lsb_pixel_embed_extract regression: fail");
                $finish;
            end
        end
    end

    // Output stall pattern, with one long hold-off on request
    initial begin : stall_pattern
        int kind;
        int len;
        int period;
        forever begin
            kind   = $urandom_range(0, 3);
            len    = $urandom_range(10, 150);
            period = $urandom_range(2, 7);
            for (int c = 0; c < len; c++) begin
                @(posedge i_clk);
                if (hold_req) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (kind)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 99) < 25);
                        2:       i_stall <= ($urandom_range(0, 99) < 70);
                        default: i_stall <= (c % period == 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row    rows [DIR_N];
        t_pixel      px;
        logic        m;
        logic [31:0] pos32;
        logic [31:0] pl32;
        logic [31:0] img32;
        int          kind;
        int          n;
        bit          pressure_done;

        pressure_done = 1'b0;

        // Header: extract nibbles 3, 2, 1 and 0 at pixels 0-2 and 7, length 0x123
        rows[0]  = dir_row(MODE_EXTRACT, '0, IMG_MAX, 32'hFFFF_0000, 8'h00,
                           1'b1, 32'hFFFF_0000, 1'b0, 32'd0, 1'b0);
        rows[1]  = dir_row(MODE_EXTRACT, '0, IMG_MAX, 32'h807F_FEFE, 8'hFF,
                           1'b1, 32'h807F_FEFE, 1'b0, 32'd0, 1'b0);
        rows[2]  = dir_row(MODE_EXTRACT, '0, IMG_MAX, 32'h0100_FE80, 8'h5A,
                           1'b1, 32'h0100_FE80, 1'b0, 32'd0, 1'b0);
        // Embed with reset settings and with an empty image: no room
        rows[3]  = dir_row(MODE_EMBED, '0, IMG_RESET, 32'h55AA_FF00, 8'h00,
                           1'b1, 32'h55AA_FF00, 1'b0, 32'd0, 1'b1);
        rows[4]  = dir_row(MODE_EMBED, '0, '0, 32'h0102_0304, 8'hFF,
                           1'b1, 32'h0102_0304, 1'b0, 32'd0, 1'b1);
        // Largest length that fits the clamped image, then one more
        rows[5]  = dir_row(MODE_EMBED, PL_FIT_MAX, IMG_MAX, 32'h0000_0000, 8'hFF,
                           1'b1, 32'h0101_0100, 1'b0, 32'd0, 1'b0);
        rows[6]  = dir_row(MODE_EMBED, PL_OVER, IMG_MAX, 32'hFFFF_FFFF, 8'h00,
                           1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1);
        rows[7]  = dir_row(MODE_EXTRACT, PL_OVER, IMG_MAX, 32'h00FE_807E, 8'h00,
                           1'b1, 32'h00FE_807E, 1'b1, 32'h123, 1'b0);
        rows[8]  = dir_row(MODE_EXTRACT, PL_OVER, IMG_MAX, 32'h1357_9BDF, 8'h66,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[9]  = dir_row(MODE_EXTRACT, PL_OVER, IMG_MAX, 32'h2468_ACE1, 8'h99,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        // Pixel past the image: no byte, length still shown
        rows[10] = dir_row(MODE_EXTRACT, PL_OVER, 25'd4, 32'hFFFF_FFFF, 8'h00,
                           1'b1, 32'hFFFF_FFFF, 1'b0, 32'h123, 1'b0);
        rows[11] = dir_row(MODE_EMBED, 23'd20, 25'd100, 32'hC3C3_C3C3, 8'h5A,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[12] = dir_row(MODE_EMBED, 23'd20, 25'd100, 32'h3C3C_3C3C, 8'hA5,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[13] = dir_row(MODE_EMBED, 23'd20, 25'd100, 32'h0F0F_0F0F, 8'h00,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[14] = dir_row(MODE_EXTRACT, 23'd20, IMG_MAX, 32'h7E7E_7E7E, 8'hFF,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[15] = dir_row(MODE_EXTRACT, 23'd20, IMG_MAX, 32'h8181_8181, 8'h0F,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);
        rows[16] = dir_row(MODE_EMBED, '0, 25'd100, 32'hF0F0_F0F0, 8'hFF,
                           1'b0, '0, 1'b0, 32'd0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table, rewriting registers only when a row needs it
        for (int k = 0; k < DIR_N; k++) begin
            if (rows[k].mode !== cfg_mode || rows[k].plen !== cfg_plen ||
                rows[k].img !== cfg_img) begin
                drain_results();
                apply_config(rows[k].mode, rows[k].plen, rows[k].img);
            end
            send_pixel(rows[k].px, rows[k].typed, rows[k].want);
        end

        // Random phases: mostly embed runs that fit and extract runs inside the image
        while (items_sent < TOTAL_ITEMS) begin
            kind  = $urandom_range(0, 9);
            n     = $urandom_range(8, 60);
            pos32 = 32'(pix_pos);
            if (kind <= 3) begin
                m     = MODE_EMBED;
                pl32  = (pos32 - HDR_PIX) / 2 + $urandom_range(0, n / 2 + 4);
                pl32  = pl32 - $urandom_range(0, 3);
                img32 = 2 * pl32 + HDR_PIX + 2 + $urandom_range(0, 100);
                if (img32 < pos32 + n && $urandom_range(0, 3) != 0)
                    img32 = pos32 + n + $urandom_range(0, 20);
            end else if (kind <= 7) begin
                m     = MODE_EXTRACT;
                pl32  = $urandom_range(0, 32'(PL_MAX));
                img32 = pos32 + $urandom_range(0, n + 40);
            end else begin
                m = (kind == 8) ? MODE_EMBED : MODE_EXTRACT;
                case ($urandom_range(0, 2))
                    0:       pl32 = 32'd0;
                    1:       pl32 = 32'(PL_MAX);
                    default: pl32 = $urandom_range(0, 32'(PL_MAX));
                endcase
                case ($urandom_range(0, 4))
                    0:       img32 = 32'd0;
                    1:       img32 = 32'd1;
                    2:       img32 = 32'(PIX_CAP);
                    3:       img32 = 32'(IMG_MAX);
                    default: img32 = $urandom_range(0, 32'(IMG_MAX));
                endcase
            end
            drain_results();
            apply_config(m, pl32[PL_W-1:0], img32[IMG_W-1:0]);
            // Hold the output once while a long phase keeps offering words
            if (!pressure_done && items_sent >= PRESSURE_AT) begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
                n             = 80;
            end
            repeat (n) begin
                px = t_pixel'({$urandom(), 8'($urandom())});
                send_pixel(px, 1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("lsb_pixel_embed_extract regression: pass");
        end else begin
            $display("lsb_pixel_embed_extract regression: fail");
        end
        $finish;
    end

endmodule
